/* rtl/wsd_pkg.sv */
`default_nettype none

package wsd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 64;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wsd_if.sv */
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  frame_opcode;
  logic        is_masked;
  logic [63:0] payload_length;
  logic [7:0]  data_byte;
  logic        last;

  modport source (
    output valid, output kind, output frame_opcode, output is_masked,
    output payload_length, output data_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input frame_opcode, input is_masked,
    input payload_length, input data_byte, input last, output ready
  );
endinterface

`default_nettype wire

/* rtl/websocket_frame_deframer_unmask.sv */
// WebSocket receive deframer: takes one stream byte per item and gives a header item when a
// frame header is complete, then one unmasked payload item per payload byte, with last set
// on the final item of the frame. It accepts a byte in every cycle while its output register
// is empty or being drained, so the sustained rate is one byte per cycle; a result appears in
// the cycle after the byte that causes it. Both follow from the single per-byte state update
// in the parser feeding one output register, whose ready is the only back-pressure path.
`default_nettype none

module websocket_frame_deframer_unmask
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  wsd_in_if.sink    rx,
  wsd_out_if.source result
);

  logic    accept;
  logic    can_load;
  logic    res_valid;
  result_t res;

  assign rx.ready = can_load;
  assign accept   = rx.valid && can_load;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx.rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  wsd_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (res_valid),
    .res     (res),
    .can_load(can_load),
    .result  (result)
  );

endmodule

`default_nettype wire

/* rtl/wsd_parser.sv */
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output result_t         res
);

  phase_t                 phase, phase_next;
  logic [3:0]             held_opcode, held_opcode_next;
  logic                   held_mask_flag, held_mask_flag_next;
  logic [LENGTH_BITS-1:0] length_accumulator, length_accumulator_next;
  logic [3:0]             header_bytes_left, header_bytes_left_next;
  logic [7:0]             mask_key [4];
  logic [1:0]             key_position, key_position_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;

  logic                   key_we;
  logic [1:0]             key_idx;
  logic                   emit_hdr;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic [LENGTH_BITS-1:0] acc_shift;
  logic [LENGTH_BITS-1:0] pl_dec;
  logic [3:0]             hbl_dec;
  logic [7:0]             key_byte;

  always_comb begin
    phase_next              = phase;
    held_opcode_next        = held_opcode;
    held_mask_flag_next     = held_mask_flag;
    length_accumulator_next = length_accumulator;
    header_bytes_left_next  = header_bytes_left;
    key_position_next       = key_position;
    payload_left_next       = payload_left;
    key_we                  = 1'b0;
    key_idx                 = 2'(3'd4 - header_bytes_left[2:0]);
    emit_hdr                = 1'b0;
    hdr_len                 = length_accumulator;
    acc_shift               = {length_accumulator[LENGTH_BITS-9:0], rx_byte};
    hbl_dec                 = (header_bytes_left != 4'd0) ? header_bytes_left - 4'd1 : 4'd0;
    pl_dec                  = (payload_left != '0) ? payload_left - LENGTH_BITS'(1) : '0;
    key_byte                = held_mask_flag ? mask_key[key_position] : 8'd0;
    res_valid               = 1'b0;
    res                     = '0;

    if (accept) begin
      case (phase)
        PH_FIRST: begin
          held_opcode_next = rx_byte[3:0];
          phase_next       = PH_SECOND;
        end
        PH_SECOND: begin
          held_mask_flag_next = rx_byte[7];
          if (rx_byte[6:0] == LEN_EXT16) begin
            length_accumulator_next = '0;
            header_bytes_left_next  = EXT16_BYTES;
            phase_next              = PH_EXTLEN;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            length_accumulator_next = '0;
            header_bytes_left_next  = EXT64_BYTES;
            phase_next              = PH_EXTLEN;
          end else begin
            length_accumulator_next = LENGTH_BITS'(rx_byte[6:0]);
            if (rx_byte[7]) begin
              header_bytes_left_next = KEY_BYTES;
              phase_next             = PH_KEY;
            end else begin
              emit_hdr = 1'b1;
              hdr_len  = LENGTH_BITS'(rx_byte[6:0]);
            end
          end
        end
        PH_EXTLEN: begin
          length_accumulator_next = acc_shift;
          header_bytes_left_next  = hbl_dec;
          if (hbl_dec == 4'd0) begin
            if (held_mask_flag) begin
              header_bytes_left_next = KEY_BYTES;
              phase_next             = PH_KEY;
            end else begin
              emit_hdr = 1'b1;
              hdr_len  = acc_shift;
            end
          end
        end
        PH_KEY: begin
          key_we                 = 1'b1;
          header_bytes_left_next = hbl_dec;
          if (hbl_dec == 4'd0) begin
            emit_hdr = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          key_position_next  = key_position + 2'd1;
          payload_left_next  = pl_dec;
          res_valid          = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.frame_opcode   = held_opcode;
          res.is_masked      = held_mask_flag;
          res.data_byte      = rx_byte ^ key_byte;
          res.last           = (pl_dec == '0);
          if (pl_dec == '0) begin
            phase_next = PH_FIRST;
          end
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase

      if (emit_hdr) begin
        res_valid          = 1'b1;
        res.kind           = KIND_HEADER;
        res.frame_opcode   = held_opcode;
        res.is_masked      = held_mask_flag_next;
        res.payload_length = 64'(hdr_len);
        res.last           = (hdr_len == '0);
        if (hdr_len == '0) begin
          phase_next = PH_FIRST;
        end else begin
          phase_next        = PH_PAYLOAD;
          payload_left_next = hdr_len;
          key_position_next = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_FIRST;
      held_opcode        <= 4'd0;
      held_mask_flag     <= 1'b0;
      length_accumulator <= '0;
      header_bytes_left  <= 4'd0;
      key_position       <= 2'd0;
      payload_left       <= '0;
    end else begin
      phase              <= phase_next;
      held_opcode        <= held_opcode_next;
      held_mask_flag     <= held_mask_flag_next;
      length_accumulator <= length_accumulator_next;
      header_bytes_left  <= header_bytes_left_next;
      key_position       <= key_position_next;
      payload_left       <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      mask_key[key_idx] <= rx_byte;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_left != '0))
    else $error("payload phase entered with nothing left to deliver");

  a_key_needs_mask: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_KEY) |-> (held_mask_flag && header_bytes_left != 4'd0
                           && header_bytes_left <= KEY_BYTES))
    else $error("key phase without mask flag or with bad byte count");

  a_extlen_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXTLEN) |-> (header_bytes_left != 4'd0
                              && header_bytes_left <= EXT64_BYTES))
    else $error("extended length byte count out of range");

  a_header_then_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_HEADER && !res.last) |=> (phase == PH_PAYLOAD))
    else $error("non-empty frame header not followed by payload phase");

endmodule

`default_nettype wire

/* rtl/wsd_out_reg.sv */
`default_nettype none

module wsd_out_reg
  import wsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         can_load,
  wsd_out_if.source    result
);

  logic    valid;
  result_t held;

  assign can_load = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= res;
    end
  end

  assign result.valid          = valid;
  assign result.kind           = held.kind;
  assign result.frame_opcode   = held.frame_opcode;
  assign result.is_masked      = held.is_masked;
  assign result.payload_length = held.payload_length;
  assign result.data_byte      = held.data_byte;
  assign result.last           = held.last;

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
  import wsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_LEN   = 26;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int IDLE_PCT [4]   = '{0, 55, 0, 26};
  localparam int STALL_PCT [4]  = '{0, 0, 55, 26};

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{8'h81, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_HEADER, 4'h1, 1'b0, 64'd0, 8'h00, 1'b1}},
    '{8'h8F, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, '{KIND_HEADER, 4'hF, 1'b0, 64'd1, 8'h00, 1'b0}},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 4'hF, 1'b0, 64'd0, 8'hFF, 1'b1}},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'hFE, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_HEADER, 4'h2, 1'b1, 64'd2, 8'h00, 1'b0}},
    '{8'hA5, 1'b0, NO_RESULT},
    '{8'h5A, 1'b0, NO_RESULT},
    '{8'h70, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, '{KIND_HEADER, 4'h0, 1'b0, 64'd1, 8'h00, 1'b0}},
    '{8'h00, 1'b1, '{KIND_PAYLOAD, 4'h0, 1'b0, 64'd0, 8'h00, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;

  wsd_in_if  rx_if ();
  wsd_out_if res_if ();

  websocket_frame_deframer_unmask dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if)
  );

  phase_t      rx_phase;
  logic [3:0]  held_op;
  logic        held_masked;
  logic [63:0] len_acc;
  logic [3:0]  hdr_left;
  logic [7:0]  mask_key [4];
  logic [1:0]  key_idx;
  logic [63:0] bytes_left;

  result_t     due_results [$];
  int          items_sent;
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  int unsigned quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void deframe_byte(input logic [7:0] b, output logic produced,
                                       output result_t r);
    logic length_known;
    logic key_done;
    length_known = 1'b0;
    key_done = 1'b0;
    produced = 1'b0;
    r = '0;
    case (rx_phase)
      PH_FIRST: begin
        held_op = b[3:0];
        rx_phase = PH_SECOND;
      end
      PH_SECOND: begin
        held_masked = b[7];
        len_acc = '0;
        if (b[6:0] == LEN_EXT16) begin
          rx_phase = PH_EXTLEN;
          hdr_left = EXT16_BYTES;
        end else if (b[6:0] == LEN_EXT64) begin
          rx_phase = PH_EXTLEN;
          hdr_left = EXT64_BYTES;
        end else begin
          len_acc = 64'(b[6:0]);
          length_known = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        length_known = (hdr_left == 4'd0);
      end
      PH_KEY: begin
        mask_key[2'(KEY_BYTES - hdr_left)] = b;
        hdr_left = hdr_left - 4'd1;
        key_done = (hdr_left == 4'd0);
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 64'd1;
        produced = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.frame_opcode = held_op;
        r.is_masked = held_masked;
        r.data_byte = held_masked ? (b ^ mask_key[key_idx]) : b;
        r.last = (bytes_left == 64'd0);
        key_idx = key_idx + 2'd1;
        if (bytes_left == 64'd0) rx_phase = PH_FIRST;
      end
      default: rx_phase = PH_FIRST;
    endcase
    if (length_known && held_masked) begin
      rx_phase = PH_KEY;
      hdr_left = KEY_BYTES;
    end else if (length_known || key_done) begin
      produced = 1'b1;
      r.kind = KIND_HEADER;
      r.frame_opcode = held_op;
      r.is_masked = held_masked;
      r.payload_length = len_acc;
      r.last = (len_acc == 64'd0);
      if (len_acc == 64'd0) begin
        rx_phase = PH_FIRST;
      end else begin
        rx_phase = PH_PAYLOAD;
        bytes_left = len_acc;
        key_idx = 2'd0;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input result_t want = '0);
    logic    produced;
    result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    deframe_byte(b, produced, r);
    if (produced || typed) due_results = {due_results, typed ? want : r};
    items_sent++;
  endtask

  task automatic send_random_frame();
    int unsigned len;
    logic [63:0] len_field;
    logic        masked;
    int          form;
    masked = 1'($urandom);
    form = $urandom_range(0, 9);
    if (form < 7)
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
    else
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700) : $urandom_range(0, 12);
    len_field = 64'(len);
    send_byte(8'($urandom));
    if (form < 7) begin
      send_byte({masked, len_field[6:0]});
    end else if (form < 9) begin
      send_byte({masked, LEN_EXT16});
      send_byte(len_field[15:8]);
      send_byte(len_field[7:0]);
    end else begin
      send_byte({masked, LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(len_field[8 * i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (len) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst !== 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = '{res_if.kind, res_if.frame_opcode, res_if.is_masked, res_if.payload_length,
              res_if.data_byte, res_if.last};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d op=%h masked=%0d len=%h data=%h last=%0d",
                   got.kind, got.frame_opcode, got.is_masked, got.payload_length,
                   got.data_byte, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.frame_opcode !== want.frame_opcode ||
            got.is_masked !== want.is_masked || got.payload_length !== want.payload_length ||
            got.data_byte !== want.data_byte || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind=%0d op=%h masked=%0d len=%h data=%h last=%0d",
                     want.kind, want.frame_opcode, want.is_masked, want.payload_length,
                     want.data_byte, want.last);
            $display("          got      kind=%0d op=%h masked=%0d len=%h data=%h last=%0d",
                     got.kind, got.frame_opcode, got.is_masked, got.payload_length,
                     got.data_byte, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= '0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    rx_phase = PH_FIRST;
    held_op = '0;
    held_masked = 1'b0;
    len_acc = '0;
    hdr_left = '0;
    key_idx = '0;
    bytes_left = '0;
    foreach (mask_key[i]) mask_key[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      while (items_sent < DIRECTED_LEN + (p + 1) * RANDOM_ITEMS / 4) send_random_frame();
      if (due_results.size() != 0) begin
        rx_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end
    end

    // A 64-bit length with its top bit set can never finish, so this frame closes the run.
    send_byte(8'h89);
    send_byte({1'b1, LEN_EXT64});
    send_byte(8'h80);
    repeat (7) send_byte(8'h00);
    repeat (4) send_byte(8'($urandom));
    repeat (6) send_byte(8'($urandom));

    rx_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* websocket_frame_deframer_unmask.f */
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/wsd_parser.sv
rtl/wsd_out_reg.sv
rtl/websocket_frame_deframer_unmask.sv
test/tb.sv
